// File: hdl/step_response_pd_autotuner_defines.svh
// Assertion macros for the step response PD autotuner.
// Included by the top level; no other dependencies.
`ifndef STEP_RESPONSE_PD_AUTOTUNER_DEFINES_SVH
`define STEP_RESPONSE_PD_AUTOTUNER_DEFINES_SVH
`ifndef SYNTH
`define SPDAT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("property violated");
`define SPDAT_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define SPDAT_ASSERT(label, clk, rst, prop)
`define SPDAT_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// File: hdl/spdat_pkg.sv
// Shared types, codes and fixed-point constants of the step response PD autotuner.
// No dependencies; used by the interfaces, the divider and the top level.
`default_nettype none
package spdat_pkg;

   localparam int SAMPLES_DEF = 200;
   localparam int CSR_W       = 15;
   localparam int POS_W       = 12;
   localparam int CUR_W       = 16;
   localparam int KP_W        = 19;
   localparam int KD_W        = 18;
   localparam int PLANT_W     = 32;
   localparam int KDC_W       = 26;

   localparam logic [KDC_W-1:0]        KD_Q32    = 26'd48328061;
   localparam logic [PLANT_W-1:0]      PLANT_Q16 = 32'd2587257577;
   localparam logic signed [KP_W-1:0]  KP_Q16    = -19'sd163840;
   localparam logic [KD_W-1:0]         KD_MAX    = 18'h3FFFF;

   localparam logic [10:0] STEP_SIZE_RST      = 11'd300;
   localparam logic [10:0] POSITION_LIMIT_RST = 11'd1530;
   localparam logic [14:0] CURRENT_LIMIT_RST  = 15'd8000;
   localparam logic [10:0] MIN_STEP_RST       = 11'd10;

   typedef enum logic [1:0] {
      REG_STEP_SIZE      = 2'd0,
      REG_POSITION_LIMIT = 2'd1,
      REG_CURRENT_LIMIT  = 2'd2,
      REG_MIN_STEP       = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_COLLECT = 2'd1,
      PH_DONE    = 2'd2,
      PH_FAIL    = 2'd3
   } phase_type;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_TICK  = 1'b1
   } cmd_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage
`default_nettype wire

// File: hdl/spdat_if.sv
// Valid/ready channels for request and response words of the autotuner.
// Depends on spdat_pkg.
`default_nettype none
interface spdat_req_if;
   import spdat_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    cmd;
   logic signed [POS_W-1:0] position;

   modport source (output valid, output cmd, output position, input ready);
   modport sink (input valid, input cmd, input position, output ready);
endinterface

interface spdat_rsp_if;
   import spdat_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [CUR_W-1:0] drive_current;
   logic [1:0]              phase;
   logic signed [KP_W-1:0]  kp_gain;
   logic [KD_W-1:0]         kd_gain;
   logic [PLANT_W-1:0]      plant_gain;

   modport source (output valid, output drive_current, output phase, output kp_gain,
                   output kd_gain, output plant_gain, input ready);
   modport sink (input valid, input drive_current, input phase, input kp_gain,
                 input kd_gain, input plant_gain, output ready);
endinterface
`default_nettype wire

// File: hdl/spdat_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on spdat_pkg for the control and status structs.
`default_nettype none
module spdat_div #(
   parameter int DVD_W = spdat_pkg::PLANT_W,
   parameter int DVS_W = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire spdat_pkg::div_ctrl_type    ctrl,
   input  wire logic [DVD_W-1:0]           dividend,
   input  wire logic [DVS_W-1:0]           divisor,
   output      spdat_pkg::div_stat_type    stat,
   output      logic [DVD_W-1:0]           quotient
);
   import spdat_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [CNT_W-1:0] count_ff;
   logic             done_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] rem_in;
   logic [DVD_W-1:0] quo_ff;
   logic [DVD_W-1:0] quo_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W:0]   shifted;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      fits    = shifted >= {1'b0, dvs_ff};
      rem_in  = fits ? DVS_W'(shifted - {1'b0, dvs_ff}) : shifted[DVS_W-1:0];
      quo_in  = {quo_ff[DVD_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            count_ff <= CNT_W'(DVD_W);
         end else if (count_ff != '0) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (count_ff != '0) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign stat.busy = count_ff != '0;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule
`default_nettype wire

// File: hdl/step_response_pd_autotuner.sv
// Top level of the step response PD autotuner: sequencer, sample tracking, results.
// Depends on spdat_pkg, spdat_if.sv, spdat_div and the assertion macro header.
//
//   channel   direction  handshake          payload
//   req_chan  in         valid/ready        cmd, position
//   rsp_chan  out        valid/ready        drive_current, phase, kp_gain, kd_gain,
//                                           plant_gain
//   csr_*     in         csr_we             csr_index, csr_wdata
//
// An ordinary word is accepted, evaluated and then presented as the response.
// The final sample of a successful run also passes through the serial divider
// that forms the plant gain (one quotient bit per cycle, 32 bits).
// Reset is synchronous and needs no clearing pass; the block is ready right after it.
// A stalled response holds; no new request word is taken until it leaves.
`default_nettype none
`include "step_response_pd_autotuner_defines.svh"
module step_response_pd_autotuner #(
   parameter int SAMPLES = spdat_pkg::SAMPLES_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   spdat_req_if.sink                       req_chan,
   spdat_rsp_if.source                     rsp_chan,
   input  wire logic                       csr_we,
   input  wire spdat_pkg::reg_index_type   csr_index,
   input  wire logic [spdat_pkg::CSR_W-1:0] csr_wdata
);
   import spdat_pkg::*;

   localparam int CNT_W = $clog2(SAMPLES + 1);
   localparam int P2_W  = 2 * CNT_W;
   localparam int KDP_W = (CNT_W + KDC_W > 34) ? (CNT_W + KDC_W) : 34;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EVAL = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [10:0]              step_size_ff;
   logic [10:0]              position_limit_ff;
   logic [14:0]              current_limit_ff;
   logic [10:0]              min_step_ff;

   logic                     cmd_ff;
   logic signed [POS_W-1:0]  pos_ff;

   phase_type                phase_ff, phase_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [POS_W-1:0]  target_ff, target_in;
   logic signed [POS_W-1:0]  start_ff, start_in;
   logic signed [POS_W-1:0]  prev_ff, prev_in;
   logic signed [POS_W-1:0]  older_ff, older_in;
   logic [CNT_W-1:0]         peak_ff, peak_in;
   logic                     kp_set_ff, kp_set_in;
   logic [KD_W-1:0]          kd_ff, kd_in;
   logic [PLANT_W-1:0]       plant_ff;
   logic signed [CUR_W-1:0]  drive_ff, drive_in;

   logic signed [12:0]       lim;
   logic signed [12:0]       pos13;
   logic signed [12:0]       tgt_raw;
   logic signed [12:0]       tgt_clamp;
   logic                     at_limit;
   logic [CNT_W-1:0]         count_inc;
   logic signed [13:0]       err;
   logic signed [16:0]       neg5;
   logic signed [16:0]       half;
   logic signed [16:0]       cur_lim;
   logic signed [16:0]       amp;
   logic signed [13:0]       moved;
   logic [13:0]              moved_abs;
   logic [KDP_W-1:0]         kd_prod;
   logic [KD_W-1:0]          kd_val;
   logic [P2_W-1:0]          p2;
   logic                     go_div;

   div_ctrl_type             div_ctrl;
   div_stat_type             div_stat;
   logic [PLANT_W-1:0]       div_quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff      <= STEP_SIZE_RST;
         position_limit_ff <= POSITION_LIMIT_RST;
         current_limit_ff  <= CURRENT_LIMIT_RST;
         min_step_ff       <= MIN_STEP_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_STEP_SIZE:      step_size_ff      <= csr_wdata[10:0];
            REG_POSITION_LIMIT: position_limit_ff <= csr_wdata[10:0];
            REG_CURRENT_LIMIT:  current_limit_ff  <= csr_wdata[14:0];
            REG_MIN_STEP:       min_step_ff       <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         cmd_ff <= req_chan.cmd;
         pos_ff <= req_chan.position;
      end
   end

   always_comb begin
      lim       = signed'({2'b00, position_limit_ff});
      pos13     = 13'(pos_ff);
      tgt_raw   = pos13 + signed'({2'b00, step_size_ff});
      tgt_clamp = tgt_raw;
      if (tgt_clamp < -lim) begin
         tgt_clamp = -lim;
      end
      if (tgt_clamp > lim) begin
         tgt_clamp = lim;
      end
      at_limit  = (pos13 <= -lim) || (pos13 >= lim);
      count_inc = count_ff + 1'b1;

      err     = 14'(target_ff) - 14'(pos_ff);
      neg5    = -(17'(err) * 17'sd5);
      half    = (neg5 + signed'(17'(neg5 < 0))) >>> 1;
      cur_lim = signed'({2'b00, current_limit_ff});
      amp     = half;
      if (amp > cur_lim) begin
         amp = cur_lim;
      end
      if (amp < -cur_lim) begin
         amp = -cur_lim;
      end

      phase_in  = phase_ff;
      count_in  = count_ff;
      target_in = target_ff;
      start_in  = start_ff;
      prev_in   = prev_ff;
      older_in  = older_ff;
      peak_in   = peak_ff;
      kp_set_in = kp_set_ff;
      kd_in     = kd_ff;
      drive_in  = '0;
      go_div    = 1'b0;

      if (cmd_ff == CMD_START) begin
         start_in  = pos_ff;
         target_in = tgt_clamp[POS_W-1:0];
         count_in  = '0;
         peak_in   = '0;
         prev_in   = '0;
         older_in  = '0;
         kp_set_in = 1'b0;
         kd_in     = '0;
         phase_in  = PH_COLLECT;
      end else if (phase_ff == PH_COLLECT) begin
         if (at_limit) begin
            phase_in = PH_FAIL;
         end else begin
            if (count_ff >= CNT_W'(2) && peak_ff == '0 && prev_ff > older_ff
                && prev_ff > pos_ff) begin
               peak_in = count_ff - 1'b1;
            end
            older_in = prev_ff;
            prev_in  = pos_ff;
            count_in = count_inc;
            if (count_inc >= CNT_W'(SAMPLES)) begin
               if (peak_in == '0 || moved_abs < 14'(min_step_ff)) begin
                  phase_in = PH_FAIL;
               end else begin
                  phase_in  = PH_DONE;
                  kp_set_in = 1'b1;
                  kd_in     = kd_val;
                  go_div    = 1'b1;
               end
            end else begin
               drive_in = amp[CUR_W-1:0];
            end
         end
      end
   end

   always_comb begin
      moved     = 14'(target_ff) - 14'(start_ff);
      moved_abs = (moved < 0) ? 14'(-moved) : 14'(moved);
      kd_prod   = KDP_W'(peak_in) * KDP_W'(KD_Q32);
      kd_val    = ((kd_prod >> 16) > KDP_W'(KD_MAX)) ? KD_MAX : kd_prod[33:16];
      p2        = P2_W'(peak_in) * P2_W'(peak_in);
   end

   assign div_ctrl.start = (state_ff == ST_EVAL) && go_div;

   spdat_div #(
      .DVD_W (PLANT_W),
      .DVS_W (P2_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (PLANT_Q16),
      .divisor  (p2),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: state_in = go_div ? ST_DIV : ST_OUT;
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         phase_ff  <= PH_IDLE;
         count_ff  <= '0;
         target_ff <= '0;
         start_ff  <= '0;
         prev_ff   <= '0;
         older_ff  <= '0;
         peak_ff   <= '0;
         kp_set_ff <= 1'b0;
         kd_ff     <= '0;
         plant_ff  <= '0;
         drive_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_EVAL) begin
            phase_ff  <= phase_in;
            count_ff  <= count_in;
            target_ff <= target_in;
            start_ff  <= start_in;
            prev_ff   <= prev_in;
            older_ff  <= older_in;
            peak_ff   <= peak_in;
            kp_set_ff <= kp_set_in;
            kd_ff     <= kd_in;
            drive_ff  <= drive_in;
         end
         if (state_ff == ST_DIV && div_stat.done) begin
            plant_ff <= div_quo;
         end
      end
   end

   assign req_chan.ready         = state_ff == ST_IDLE;
   assign rsp_chan.valid         = state_ff == ST_OUT;
   assign rsp_chan.drive_current = drive_ff;
   assign rsp_chan.phase         = phase_ff;
   assign rsp_chan.kp_gain       = kp_set_ff ? KP_Q16 : '0;
   assign rsp_chan.kd_gain       = kd_ff;
   assign rsp_chan.plant_gain    = plant_ff;

   `SPDAT_ASSERT(a_busy_after_accept, clock, reset, (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
   `SPDAT_ASSERT(a_kp_only_done, clock, reset, kp_set_ff |-> (phase_ff == PH_DONE))
   `SPDAT_ASSERT(a_div_in_div_state, clock, reset, div_stat.busy |-> (state_ff == ST_DIV))
   `SPDAT_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(SAMPLES))

endmodule
`default_nettype wire

// File: dv/step_response_pd_autotuner_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the step response PD autotuner: directed table, then random
// identification runs under changing register settings and handshake pressure.
// Depends on spdat_pkg, spdat_if.sv and the step_response_pd_autotuner top level.
module step_response_pd_autotuner_tb;
   import spdat_pkg::*;

   localparam int N_SAMPLES = SAMPLES_DEF;
   localparam int SEG_WORDS = 90;
   localparam int N_SEGS    = 8;

   typedef struct packed {
      logic [CUR_W-1:0]   drive;
      phase_type          phase;
      logic [KP_W-1:0]    kp;
      logic [KD_W-1:0]    kd;
      logic [PLANT_W-1:0] plant;
   } tuner_word_t;

   typedef struct packed {
      cmd_type          cmd;
      logic [POS_W-1:0] pos;
      logic             typed_in;
      phase_type        phase;
   } dir_row_t;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   reg_index_type       csr_index;
   logic [CSR_W-1:0]    csr_wdata;

   spdat_req_if req_if();
   spdat_rsp_if rsp_if();

   step_response_pd_autotuner #(.SAMPLES(N_SAMPLES)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // register shadow
   int unsigned cfg_step = STEP_SIZE_RST;
   int unsigned cfg_lim  = POSITION_LIMIT_RST;
   int unsigned cfg_cur  = CURRENT_LIMIT_RST;
   int unsigned cfg_min  = MIN_STEP_RST;

   // tuner state
   phase_type          run_ph    = PH_IDLE;
   int unsigned        n_samples = 0;
   int                 tgt       = 0;
   int                 start_pos = 0;
   int                 prev_s    = 0;
   int                 older_s   = 0;
   int unsigned        peak_at   = 0;
   logic [KP_W-1:0]    kp_q      = '0;
   logic [KD_W-1:0]    kd_q      = '0;
   logic [PLANT_W-1:0] plant_q   = '0;

   tuner_word_t due_words[$];
   int err_count     = 0;
   int words_sent    = 0;
   int words_checked = 0;
   int runs_done     = 0;
   int runs_failed   = 0;
   int idle_pct      = 0;
   int stall_pct     = 0;

   function automatic tuner_word_t tune_response(cmd_type c, logic signed [POS_W-1:0] p);
      tuner_word_t     w;
      int              pos;
      int              lim;
      int              drv;
      int              t;
      int              moved;
      longint unsigned kd_full;
      longint unsigned p2;
      pos = p;
      lim = int'(cfg_lim);
      drv = 0;
      if (c == CMD_START) begin
         t = pos + int'(cfg_step);
         if (t < -lim) t = -lim;
         if (t > lim) t = lim;
         start_pos = pos;
         tgt       = t;
         n_samples = 0;
         peak_at   = 0;
         prev_s    = 0;
         older_s   = 0;
         kp_q      = '0;
         kd_q      = '0;
         run_ph    = PH_COLLECT;
      end else if (run_ph == PH_COLLECT) begin
         if (pos <= -lim || pos >= lim) begin
            run_ph = PH_FAIL;
            runs_failed++;
         end else begin
            if (n_samples >= 2 && peak_at == 0 && prev_s > older_s && prev_s > pos)
               peak_at = n_samples - 1;
            older_s = prev_s;
            prev_s  = pos;
            n_samples++;
            if (n_samples >= N_SAMPLES) begin
               moved = tgt - start_pos;
               if (moved < 0) moved = -moved;
               if (peak_at == 0 || moved < int'(cfg_min)) begin
                  run_ph = PH_FAIL;
                  runs_failed++;
               end else begin
                  kd_full = (64'(peak_at) * 64'(KD_Q32)) >> 16;
                  if (kd_full > 64'(KD_MAX)) kd_full = 64'(KD_MAX);
                  p2      = 64'(peak_at) * 64'(peak_at);
                  plant_q = PLANT_W'(64'(PLANT_Q16) / p2);
                  kp_q    = KP_Q16;
                  kd_q    = kd_full[KD_W-1:0];
                  run_ph  = PH_DONE;
                  runs_done++;
               end
            end else begin
               drv = -(5 * (tgt - pos)) / 2;
               if (drv > int'(cfg_cur)) drv = int'(cfg_cur);
               if (drv < -int'(cfg_cur)) drv = -int'(cfg_cur);
            end
         end
      end
      w.drive = CUR_W'(drv);
      w.phase = run_ph;
      w.kp    = kp_q;
      w.kd    = kd_q;
      w.plant = plant_q;
      return w;
   endfunction

   function automatic dir_row_t row(cmd_type c, int p, logic typed_in, phase_type ph);
      dir_row_t r;
      r.cmd      = c;
      r.pos      = POS_W'(p);
      r.typed_in = typed_in;
      r.phase    = ph;
      return r;
   endfunction

   function automatic int rand_pos(int b);
      if (b <= 0 || $urandom_range(7) == 0)
         return int'($urandom_range(4095)) - 2048;
      return int'($urandom_range(2 * b)) - b;
   endfunction

   function automatic int bound_pos(int v, int b);
      if (b < 0) return v;
      if (v > b) return b;
      if (v < -b) return -b;
      return v;
   endfunction

   task automatic report_mismatch(string msg);
      if (err_count < 50) $display("MISMATCH at response word %0d: %s", words_checked, msg);
      err_count++;
   endtask

   task automatic send_word(cmd_type c, logic [POS_W-1:0] p, logic typed_in, phase_type ph);
      tuner_word_t w;
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.cmd      <= c;
      req_if.position <= p;
      do @(posedge clock); while (!req_if.ready);
      w = tune_response(c, p);
      if (typed_in) begin
         w.drive = '0;
         w.phase = ph;
         w.kp    = '0;
         w.kd    = '0;
         w.plant = '0;
      end
      due_words.push_back(w);
      words_sent++;
   endtask

   task automatic drain_words();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (due_words.size() != 0);
      @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, int unsigned val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(val);
      @(posedge clock);
      case (idx)
         REG_STEP_SIZE:      cfg_step = val & 'h7FF;
         REG_POSITION_LIMIT: cfg_lim  = val & 'h7FF;
         REG_CURRENT_LIMIT:  cfg_cur  = val & 'h7FFF;
         REG_MIN_STEP:       cfg_min  = val & 'h7FF;
      endcase
   endtask

   task automatic apply_config(int unsigned s, int unsigned l, int unsigned c, int unsigned m);
      write_reg(REG_STEP_SIZE, s);
      write_reg(REG_POSITION_LIMIT, l);
      write_reg(REG_CURRENT_LIMIT, c);
      write_reg(REG_MIN_STEP, m);
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin : rsp_check
      tuner_word_t got;
      tuner_word_t want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.drive = rsp_if.drive_current;
         got.phase = phase_type'(rsp_if.phase);
         got.kp    = rsp_if.kp_gain;
         got.kd    = rsp_if.kd_gain;
         got.plant = rsp_if.plant_gain;
         if (due_words.size() == 0) begin
            report_mismatch("response word with nothing pending");
         end else begin
            want = due_words.pop_front();
            if (got.drive !== want.drive)
               report_mismatch($sformatf("drive_current got %0d want %0d",
                                         $signed(got.drive), $signed(want.drive)));
            if (got.phase !== want.phase)
               report_mismatch($sformatf("phase got %0d want %0d", got.phase, want.phase));
            if (got.kp !== want.kp)
               report_mismatch($sformatf("kp_gain got %0d want %0d",
                                         $signed(got.kp), $signed(want.kp)));
            if (got.kd !== want.kd)
               report_mismatch($sformatf("kd_gain got %0d want %0d", got.kd, want.kd));
            if (got.plant !== want.plant)
               report_mismatch($sformatf("plant_gain got %0d want %0d", got.plant, want.plant));
            words_checked++;
         end
      end
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      dir_row_t rows[$];
      int b;
      int v;
      int pk;
      int abort_at;
      int shape;
      int n;
      int seg_base;
      int kind;
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.cmd      <= CMD_START;
      req_if.position <= '0;
      csr_we          <= 1'b0;
      csr_index       <= REG_STEP_SIZE;
      csr_wdata       <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      rows.push_back(row(CMD_TICK,  0,     1'b1, PH_IDLE));
      rows.push_back(row(CMD_TICK,  -2048, 1'b1, PH_IDLE));
      rows.push_back(row(CMD_TICK,  2047,  1'b1, PH_IDLE));
      rows.push_back(row(CMD_START, -2048, 1'b1, PH_COLLECT));
      rows.push_back(row(CMD_TICK,  0,     1'b0, PH_IDLE));
      rows.push_back(row(CMD_TICK,  -1530, 1'b1, PH_FAIL));
      rows.push_back(row(CMD_TICK,  100,   1'b1, PH_FAIL));
      rows.push_back(row(CMD_START, 2047,  1'b1, PH_COLLECT));
      rows.push_back(row(CMD_TICK,  1530,  1'b1, PH_FAIL));
      rows.push_back(row(CMD_START, 0,     1'b1, PH_COLLECT));
      rows.push_back(row(CMD_TICK,  -1529, 1'b0, PH_IDLE));
      rows.push_back(row(CMD_TICK,  1529,  1'b0, PH_IDLE));
      rows.push_back(row(CMD_TICK,  5,     1'b0, PH_IDLE));
      rows.push_back(row(CMD_TICK,  -5,    1'b0, PH_IDLE));
      rows.push_back(row(CMD_START, 1400,  1'b1, PH_COLLECT));
      rows.push_back(row(CMD_TICK,  1529,  1'b0, PH_IDLE));
      rows.push_back(row(CMD_TICK,  -2048, 1'b1, PH_FAIL));
      rows.push_back(row(CMD_START, -1,    1'b1, PH_COLLECT));
      rows.push_back(row(CMD_TICK,  2047,  1'b1, PH_FAIL));
      rows.push_back(row(CMD_START, 1365,  1'b1, PH_COLLECT));
      rows.push_back(row(CMD_TICK,  -1366, 1'b0, PH_IDLE));
      rows.push_back(row(CMD_TICK,  682,   1'b0, PH_IDLE));
      foreach (rows[i]) send_word(rows[i].cmd, rows[i].pos, rows[i].typed_in, rows[i].phase);

      for (int seg = 0; seg < N_SEGS; seg++) begin
         drain_words();
         case (seg)
            0: ;
            1: apply_config(2047, 2047, 32767, 0);
            2: apply_config(0, 0, 0, 0);
            3: apply_config($urandom_range(600, 1), $urandom_range(2047, 200),
                            $urandom_range(32767), $urandom_range(50));
            4: apply_config(10, 2047, 100, 11);
            5: apply_config(10, 1800, 5000, 10);
            6: apply_config($urandom_range(2047), $urandom_range(2047),
                            $urandom_range(32767), $urandom_range(2047));
            default: apply_config($urandom_range(1000), $urandom_range(2047, 1000),
                                  $urandom_range(9000), $urandom_range(100));
         endcase
         idle_pct  = (seg % 4 == 1) ? 69 : (seg % 4 == 3) ? 20 : 0;
         stall_pct = (seg % 4 == 2) ? 69 : (seg % 4 == 3) ? 20 : 0;
         seg_base  = words_sent;
         while (words_sent - seg_base < SEG_WORDS) begin
            b    = int'(cfg_lim) - 1;
            kind = $urandom_range(19);
            if (kind < 9) begin
               // full identification run: overshoot, monotone or noisy trace
               shape = $urandom_range(9);
               case ($urandom_range(3))
                  0:       pk = 1;
                  1:       pk = N_SAMPLES - 2;
                  default: pk = $urandom_range(N_SAMPLES - 2, 1);
               endcase
               abort_at = ($urandom_range(5) == 0) ? $urandom_range(N_SAMPLES - 1) : N_SAMPLES;
               send_word(CMD_START, POS_W'(rand_pos(b)), 1'b0, PH_IDLE);
               v = (b > 0) ? int'($urandom_range(b)) - b : 0;
               for (int i = 0; i < N_SAMPLES; i++) begin
                  if (i == abort_at)
                     v = $urandom_range(1) ? int'(cfg_lim) : -int'(cfg_lim);
                  else if (shape < 6)
                     v = bound_pos((i <= pk) ? v + int'($urandom_range(4, 1))
                                             : v - int'($urandom_range(4, 1)), b);
                  else if (shape < 8)
                     v = bound_pos(v + int'($urandom_range(3)), b);
                  else
                     v = rand_pos(b);
                  send_word(CMD_TICK, POS_W'(v), 1'b0, PH_IDLE);
                  if (run_ph != PH_COLLECT) break;
               end
            end else if (kind < 13) begin
               send_word(CMD_START, POS_W'(rand_pos(b)), 1'b0, PH_IDLE);
               n = $urandom_range(20);
               repeat (n) send_word(CMD_TICK, POS_W'(rand_pos(b)), 1'b0, PH_IDLE);
            end else if (kind < 18) begin
               n = $urandom_range(8, 1);
               repeat (n)
                  send_word(($urandom_range(9) < 7) ? CMD_TICK : CMD_START,
                            POS_W'($urandom_range(4095)), 1'b0, PH_IDLE);
            end else begin
               drain_words();
            end
         end
      end

      drain_words();
      repeat (50) @(posedge clock);
      $display("Sent %0d request words and checked %0d response words over %0d settings",
               words_sent, words_checked, N_SEGS);
      $display("Identification runs ended: %0d tuned, %0d failed", runs_done, runs_failed);
      if (err_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
